### rtl/core/steering_torque_split_macros.svh
// assertion macros shared by the steering torque split rtl
`ifndef STEERING_TORQUE_SPLIT_MACROS_SVH
`define STEERING_TORQUE_SPLIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define STS_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define STS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/sts_pkg.sv
// shared types, constants and helpers for the steering torque split
package sts_pkg;

    localparam int ANGLE_W     = 16;
    localparam int CMD_W       = 15;
    localparam int TQ_W        = 14;
    localparam int STEER_W     = 15;
    localparam int REG_W       = 16;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 56;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;

    localparam logic [TQ_W-1:0] TORQUE_MAX = 14'd10000;

    typedef enum logic [2:0] {
        CFG_VEC_EN     = 3'd0,
        CFG_FRONT_SH   = 3'd1,
        CFG_FRONT_MAX  = 3'd2,
        CFG_REAR_MAX   = 3'd3,
        CFG_STEER_LO   = 3'd4,
        CFG_STEER_HI   = 3'd5,
        CFG_PLAIN_GAIN = 3'd6
    } t_cfg_idx;

    // per-request sideband around the ratio divider
    typedef struct packed {
        logic               deg;
        logic               rdeg;
        logic               pos;
        logic [CMD_W-1:0]   cmd;
    } t_side;

    // per-request sideband from the share math to the output
    typedef struct packed {
        logic               cpos;
        logic [TQ_W-1:0]    cmd;
        logic [TQ_W-1:0]    plf;
        logic [TQ_W-1:0]    plr;
    } t_mid;

    function automatic logic [TQ_W-1:0] sat_tq(input logic [TQ_W-1:0] q);
        sat_tq = (q > TORQUE_MAX) ? TORQUE_MAX : q;
    endfunction

endpackage

### rtl/core/sts_div.sv
// pipelined restoring divider, one quotient bit per stage
module sts_div #(
    parameter int NW = 31,
    parameter int DW = 15,
    parameter int QW = 17
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    localparam int W = DW + QW;

    logic [NW-1:0] r_n [QW-1];
    logic [DW-1:0] r_d [QW-1];
    logic [QW-1:0] r_q [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stg
        logic [NW-1:0] w_ni;
        logic [DW-1:0] w_di;
        logic [QW-1:0] w_qi;
        logic [W-1:0]  w_sh;
        logic [W-1:0]  w_nx;
        logic [W-1:0]  w_df;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_ni = i_num;
            assign w_di = i_den;
            assign w_qi = '0;
        end else begin : g_next
            assign w_ni = r_n[k-1];
            assign w_di = r_d[k-1];
            assign w_qi = r_q[k-1];
        end

        assign w_sh = W'(w_di) << (QW - 1 - k);
        assign w_nx = W'(w_ni);
        assign w_ge = (w_nx >= w_sh);
        assign w_df = w_nx - w_sh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k] <= w_ge ? (w_qi | (QW'(1) << (QW - 1 - k))) : w_qi;
            end
        end

        if (k < QW - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_n[k] <= w_ge ? w_df[NW-1:0] : w_ni;
                    r_d[k] <= w_di;
                end
            end
        end
    end

    assign o_quo = r_q[QW-1];

endmodule

### rtl/core/steering_torque_split.sv
// top level of the steering-based four-wheel torque split
`include "steering_torque_split_macros.svh"
// Usage:
// - input stream carries one request: steering angle and torque command;
//   each accepted request yields exactly one output item with four wheel
//   torques, in request order
// - apb port sets the vectoring registers; write them only while the
//   pipeline is empty, reads return the stored values, pready is always high
// - from accept to output valid a request passes one input stage,
//   SHARE_FRAC_BITS + 1 stages of the steering ratio divider, six
//   share/weight/multiply stages, fourteen stages of the per-wheel
//   divider and the output register
// - throughput is one request per cycle while the output is not stalled;
//   every stage is a register with a valid bit and the whole pipeline advances together
// - when the receiver stalls a pending output, the pipeline freezes and
//   s_axis tready drops; nothing is lost or repeated
// - synchronous reset empties the pipeline and loads the register defaults
module steering_torque_split
    import sts_pkg::*;
#(
    parameter int SHARE_FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // steer_angle [15:0], torque_command [30:16], zero [31]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // torque_front_left [13:0], torque_front_right [27:14],
    // torque_rear_left [41:28], torque_rear_right [55:42]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic [PADDR_W-1:0]     i_paddr,
    input  logic [PDATA_W-1:0]     i_pwdata,
    output logic [PDATA_W-1:0]     o_prdata,
    output logic                   o_pready
);

    localparam int F    = SHARE_FRAC_BITS;
    localparam int SW   = 2 * F + 1;
    localparam int QW1  = F + 1;
    localparam int NW1  = STEER_W + F;
    localparam int QW2  = TQ_W;
    localparam int NW2  = TQ_W + SW;
    localparam int PW   = 2 * F + 3;
    localparam int L    = 1 + QW1 + 6 + QW2 + 1;
    localparam int SL   = (F >= REG_W) ? F - REG_W : 0;
    localparam int SR   = (F < REG_W) ? REG_W - F : 0;
    localparam int XW   = F + REG_W;
    localparam logic [F:0] ONE  = (F+1)'(1) << F;
    localparam logic [F:0] HALF = (F+1)'(1) << (F - 1);

    function automatic logic [F-1:0] to_share(input logic [REG_W-1:0] v);
        logic [XW-1:0] t;
        t = (XW'(v) << SL) >> SR;
        to_share = t[F-1:0];
    endfunction

    // outer share = half + trunc(p / one), rounding toward zero
    function automatic logic [F:0] outer(input logic signed [PW-1:0] p);
        logic [PW-1:0] mag;
        logic [PW-1:0] sh;
        logic [F:0]    qq;
        mag = p[PW-1] ? PW'(-p) : PW'(p);
        sh  = mag >> F;
        qq  = sh[F:0];
        outer = p[PW-1] ? (HALF - qq) : (HALF + qq);
    endfunction

    // ---------------- configuration ----------------
    logic               r_vec;
    logic [REG_W-1:0]   r_fshare, r_fmax, r_rmax, r_gain;
    logic [STEER_W-1:0] r_slo, r_shi;
    logic               w_cfg_wr;
    t_cfg_idx           w_cfg_idx;

    assign o_pready  = 1'b1;
    assign w_cfg_wr  = i_psel && i_penable && i_pwrite && o_pready;
    assign w_cfg_idx = t_cfg_idx'(i_paddr[PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec    <= 1'b1;
            r_fshare <= 16'd24576;
            r_fmax   <= 16'd41943;
            r_rmax   <= 16'd39322;
            r_slo    <= 15'd1000;
            r_shi    <= 15'd9000;
            r_gain   <= 16'd26214;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                CFG_VEC_EN:     r_vec    <= i_pwdata[0];
                CFG_FRONT_SH:   r_fshare <= i_pwdata[REG_W-1:0];
                CFG_FRONT_MAX:  r_fmax   <= i_pwdata[REG_W-1:0];
                CFG_REAR_MAX:   r_rmax   <= i_pwdata[REG_W-1:0];
                CFG_STEER_LO:   r_slo    <= i_pwdata[STEER_W-1:0];
                CFG_STEER_HI:   r_shi    <= i_pwdata[STEER_W-1:0];
                CFG_PLAIN_GAIN: r_gain   <= i_pwdata[REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            CFG_VEC_EN:     o_prdata = PDATA_W'(r_vec);
            CFG_FRONT_SH:   o_prdata = PDATA_W'(r_fshare);
            CFG_FRONT_MAX:  o_prdata = PDATA_W'(r_fmax);
            CFG_REAR_MAX:   o_prdata = PDATA_W'(r_rmax);
            CFG_STEER_LO:   o_prdata = PDATA_W'(r_slo);
            CFG_STEER_HI:   o_prdata = PDATA_W'(r_shi);
            CFG_PLAIN_GAIN: o_prdata = PDATA_W'(r_gain);
            default:        o_prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    logic         w_en;
    logic [L-1:0] r_vld;

    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_vld[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[L-2:0], i_s_axis_tvalid};
        end
    end

    // ---------------- s1: magnitude and clamp ----------------
    logic signed [ANGLE_W-1:0] w_angle;
    logic [CMD_W-1:0]          w_cmd;
    logic [ANGLE_W-1:0]        w_d, w_dc;
    logic [STEER_W-1:0]        r1_num, r1_den;
    t_side                     r1_side;

    assign w_angle = $signed(i_s_axis_tdata[ANGLE_W-1:0]);
    assign w_cmd   = i_s_axis_tdata[ANGLE_W+CMD_W-1:ANGLE_W];
    assign w_d     = w_angle[ANGLE_W-1] ? ANGLE_W'(-w_angle) : ANGLE_W'(w_angle);
    assign w_dc    = (w_d < ANGLE_W'(r_slo)) ? ANGLE_W'(r_slo) :
                     (w_d > ANGLE_W'(r_shi)) ? ANGLE_W'(r_shi) : w_d;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_num       <= w_dc[STEER_W-1:0] - r_slo;
            r1_den       <= r_shi - r_slo;
            r1_side.deg  <= (r_shi <= r_slo);
            r1_side.rdeg <= (w_d > ANGLE_W'(r_slo));
            r1_side.pos  <= !w_angle[ANGLE_W-1] && (w_angle != '0);
            r1_side.cmd  <= w_cmd;
        end
    end

    // ---------------- steering ratio divider ----------------
    logic [QW1-1:0] w_q1;
    t_side          r_sd1 [QW1];

    sts_div #(.NW(NW1), .DW(STEER_W), .QW(QW1)) u_ratio_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num ({r1_num, {F{1'b0}}}),
        .i_den (r1_den),
        .o_quo (w_q1)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd1[0] <= r1_side;
            for (int i = 1; i < QW1; i++) begin
                r_sd1[i] <= r_sd1[i-1];
            end
        end
    end

    // ---------------- s2: ratio select, plain product ----------------
    t_side            w_s1e;
    logic [F:0]       r2_r;
    t_side            r2_side;
    logic [TQ_W+F-1:0] r2_pp;

    assign w_s1e   = r_sd1[QW1-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_r    <= w_s1e.deg ? (w_s1e.rdeg ? ONE : '0) : w_q1;
            r2_side <= w_s1e;
            r2_pp   <= w_s1e.cmd[TQ_W-1:0] * to_share(r_gain);
        end
    end

    // ---------------- s3: outer share products ----------------
    logic [F:0]               w_fdu, w_rdu;
    logic signed [PW-1:0]     w_pf, w_pr;
    logic [TQ_W+F-1:0]        w_pps;
    logic                     w_cpos3;
    logic signed [PW-1:0]     r3_pf, r3_pr;
    logic                     r3_pos;
    t_mid                     r3_mid;

    assign w_fdu   = {1'b0, to_share(r_fmax)} - HALF;
    assign w_rdu   = {1'b0, to_share(r_rmax)} - HALF;
    assign w_pf    = $signed({1'b0, r2_r}) * $signed(w_fdu);
    assign w_pr    = $signed({1'b0, r2_r}) * $signed(w_rdu);
    assign w_pps   = r2_pp >> F;
    assign w_cpos3 = !r2_side.cmd[CMD_W-1] && (r2_side.cmd != '0);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_pf       <= w_pf;
            r3_pr       <= w_pr;
            r3_pos      <= r2_side.pos;
            r3_mid.cpos <= w_cpos3;
            r3_mid.cmd  <= r2_side.cmd[TQ_W-1:0];
            r3_mid.plf  <= w_cpos3 ? sat_tq(w_pps[TQ_W-1:0]) : '0;
            r3_mid.plr  <= w_cpos3 ? sat_tq(r2_side.cmd[TQ_W-1:0]) : '0;
        end
    end

    // ---------------- s4: wheel shares ----------------
    logic [F:0] w_fo, w_ro;
    logic [F:0] r4_sh [4];
    t_mid       r4_mid;

    assign w_fo = outer(r3_pf);
    assign w_ro = outer(r3_pr);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_sh[0] <= r3_pos ? (ONE - w_fo) : w_fo;
            r4_sh[1] <= r3_pos ? w_fo : (ONE - w_fo);
            r4_sh[2] <= r3_pos ? (ONE - w_ro) : w_ro;
            r4_sh[3] <= r3_pos ? w_ro : (ONE - w_ro);
            r4_mid   <= r3_mid;
        end
    end

    // ---------------- s5: axle weighting ----------------
    logic [F:0]      w_fw, w_rw;
    logic [2*F+1:0]  w_wp [4];
    logic [SW-1:0]   r5_w [4];
    t_mid            r5_mid;

    assign w_fw = {1'b0, to_share(r_fshare)};
    assign w_rw = ONE - w_fw;

    for (genvar i = 0; i < 4; i++) begin : g_wgt
        assign w_wp[i] = r4_sh[i] * ((i < 2) ? w_fw : w_rw);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r5_w[i] <= w_wp[i][SW-1:0];
            end
            r5_mid <= r4_mid;
        end
    end

    // ---------------- s6: largest share ----------------
    logic [SW-1:0] w_m01, w_m23;
    logic [SW-1:0] r6_w [4];
    logic [SW-1:0] r6_m;
    t_mid          r6_mid;

    assign w_m01 = (r5_w[1] > r5_w[0]) ? r5_w[1] : r5_w[0];
    assign w_m23 = (r5_w[3] > r5_w[2]) ? r5_w[3] : r5_w[2];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_w   <= r5_w;
            r6_m   <= (w_m23 > w_m01) ? w_m23 : w_m01;
            r6_mid <= r5_mid;
        end
    end

    // ---------------- s7: command times share ----------------
    logic [NW2-1:0] r7_n [4];
    logic [SW-1:0]  r7_m;
    logic           r7_mz;
    t_mid           r7_mid;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                // a command at or below zero always saturates to zero
                r7_n[i] <= r6_mid.cpos ? (NW2'(r6_mid.cmd) * NW2'(r6_w[i])) : '0;
            end
            r7_m   <= r6_m;
            r7_mz  <= (r6_m == '0);
            r7_mid <= r6_mid;
        end
    end

    // ---------------- per-wheel dividers ----------------
    logic [QW2-1:0] w_q2 [4];
    t_mid           r_sd2 [QW2];
    logic [QW2-1:0] r_mz2;

    for (genvar i = 0; i < 4; i++) begin : g_wdiv
        sts_div #(.NW(NW2), .DW(SW), .QW(QW2)) u_wheel_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r7_n[i]),
            .i_den (r7_m),
            .o_quo (w_q2[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd2[0] <= r7_mid;
            for (int i = 1; i < QW2; i++) begin
                r_sd2[i] <= r_sd2[i-1];
            end
            r_mz2 <= {r_mz2[QW2-2:0], r7_mz};
        end
    end

    // ---------------- output register ----------------
    t_mid             w_me;
    logic [TQ_W-1:0]  w_vt [4];
    logic             r_out_vec;

    assign w_me = r_sd2[QW2-1];

    for (genvar i = 0; i < 4; i++) begin : g_sat
        assign w_vt[i] = r_mz2[QW2-1] ? '0 : sat_tq(w_q2[i]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_vec <= r_vec;
            if (r_vec) begin
                o_m_axis_tdata <= {w_vt[3], w_vt[2], w_vt[1], w_vt[0]};
            end else begin
                o_m_axis_tdata <= {w_me.plr, w_me.plr, w_me.plf, w_me.plf};
            end
        end
    end

    // ---------------- assertions ----------------
    `STS_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready, r_vld[0],
        "accepted request did not enter the pipeline")
    `STS_ASSERT_NOW(a_stall_blocks_input, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready, !o_s_axis_tready,
        "input taken while output stalled")
    `STS_ASSERT_NOW(a_plain_symmetric, i_clk, i_rst_n,
        o_m_axis_tvalid && !r_out_vec,
        (o_m_axis_tdata[13:0] == o_m_axis_tdata[27:14]) &&
        (o_m_axis_tdata[41:28] == o_m_axis_tdata[55:42]),
        "plain split is not left/right symmetric")

endmodule
